// ===== sv/ostmw_pkg.sv =====
// types and constants shared by the os timer match watchdog block
package ostmw_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned NumMatch = 4;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned ReqW     = 2;

  // request type bits
  localparam int unsigned ReqWriteBit = 0;
  localparam int unsigned ReqReadBit  = 1;

  // register word indexes
  localparam logic [IdxW-1:0] IdxMatch0  = 3'd0;
  localparam logic [IdxW-1:0] IdxMatch1  = 3'd1;
  localparam logic [IdxW-1:0] IdxMatch2  = 3'd2;
  localparam logic [IdxW-1:0] IdxMatch3  = 3'd3;
  localparam logic [IdxW-1:0] IdxCounter = 3'd4;
  localparam logic [IdxW-1:0] IdxStatus  = 3'd5;
  localparam logic [IdxW-1:0] IdxWdog    = 3'd6;
  localparam logic [IdxW-1:0] IdxIrqEn   = 3'd7;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [IdxW-1:0]  word_index;
    logic [DataW-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0]    read_data;
    logic [NumMatch-1:0] interrupt_lines;
    logic                watchdog_reset;
  } rsp_t;

endpackage

// ===== sv/ostmw_regs.sv =====
// timer state: match registers, counter, status, enables and the per-tick update
module ostmw_regs #(
  parameter int unsigned CounterWidth = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           upd_en_i,
  input  ostmw_pkg::req_t req_i,
  output ostmw_pkg::rsp_t rsp_o
);
  import ostmw_pkg::*;

  logic [DataW-1:0]        match_q [NumMatch];
  logic [DataW-1:0]        match_d [NumMatch];
  logic [CounterWidth-1:0] cnt_q, cnt_d;
  logic [NumMatch-1:0]     status_q, status_d;
  logic [NumMatch-1:0]     ien_q, ien_d;
  logic                    wdog_q, wdog_d;

  logic                    wr_en;
  logic                    rd_en;
  logic [NumMatch-1:0]     status_clr;
  logic [NumMatch-1:0]     hit;
  logic [DataW-1:0]        cnt_ext;
  logic [DataW-1:0]        rd_data;

  assign wr_en = req_i.req_type[ReqWriteBit];
  assign rd_en = req_i.req_type[ReqReadBit];

  // write lands first, then the counter advances, then compares see both
  always_comb begin
    for (int k = 0; k < NumMatch; k++) begin
      match_d[k] = match_q[k];
    end
    status_clr = status_q;
    ien_d      = ien_q;
    wdog_d     = wdog_q;
    if (wr_en) begin
      unique case (req_i.word_index) inside
        IdxMatch0, IdxMatch1, IdxMatch2, IdxMatch3: begin
          match_d[req_i.word_index[1:0]] = req_i.write_data;
        end
        IdxStatus: status_clr = status_q & ~req_i.write_data[NumMatch-1:0];
        IdxWdog:   wdog_d     = req_i.write_data[0];
        IdxIrqEn:  ien_d      = req_i.write_data[NumMatch-1:0];
        default: ;
      endcase
    end

    cnt_d   = cnt_q + CounterWidth'(1);
    cnt_ext = DataW'(cnt_d);

    for (int k = 0; k < NumMatch; k++) begin
      hit[k] = (match_d[k] == cnt_ext) && ien_d[k];
    end
    status_d = status_clr | hit;

    rd_data = '0;
    if (rd_en) begin
      unique case (req_i.word_index) inside
        IdxMatch0, IdxMatch1, IdxMatch2, IdxMatch3: begin
          rd_data = match_d[req_i.word_index[1:0]];
        end
        IdxCounter: rd_data = cnt_ext;
        IdxStatus:  rd_data = DataW'(status_d);
        IdxWdog:    rd_data = DataW'(wdog_d);
        default:    rd_data = DataW'(ien_d);
      endcase
    end

    rsp_o.read_data       = rd_data;
    rsp_o.interrupt_lines = status_d & ien_d;
    rsp_o.watchdog_reset  = (match_d[IdxMatch3[1:0]] == cnt_ext) && wdog_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumMatch; k++) begin
        match_q[k] <= '0;
      end
      cnt_q    <= '0;
      status_q <= '0;
      ien_q    <= '0;
      wdog_q   <= 1'b0;
    end else if (upd_en_i) begin
      for (int k = 0; k < NumMatch; k++) begin
        match_q[k] <= match_d[k];
      end
      cnt_q    <= cnt_d;
      status_q <= status_d;
      ien_q    <= ien_d;
      wdog_q   <= wdog_d;
    end
  end

endmodule

// ===== sv/os_timer_match_watchdog.sv =====
// top level of the os timer with four match registers and watchdog
// Each accepted input word is one timer tick, optionally carrying a register
// write and/or read. The block takes one word per clock cycle while in_ready_o is high,
// and returns one result word per input word, in the cycle after acceptance, from an output
// register; the state update (write, counter increment, match compares) is a
// single combinational pass into that register, so the counter advances only
// on accepted words. in_ready_o drops only while a held result is not taken.
module os_timer_match_watchdog #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ostmw_pkg::req_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ostmw_pkg::rsp_t out_data_o
);
  import ostmw_pkg::*;

  logic accept;
  logic out_valid_q, out_valid_d;
  rsp_t rsp;
  rsp_t out_data_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ostmw_regs #(
    .CounterWidth(COUNTER_WIDTH)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_en_i(accept),
    .req_i   (in_data_i),
    .rsp_o   (rsp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== dv/ostmw_timer_checker.sv =====
// checker for the os timer match watchdog: predicts each result word and compares it
module ostmw_timer_checker #(
  parameter int unsigned CounterW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  ostmw_pkg::req_t in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  ostmw_pkg::rsp_t out_data_i,
  output int unsigned     fail_cnt_o,
  output int unsigned     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ostmw_pkg::*;

  localparam logic [DataW-1:0] CntMask = {DataW{1'b1}} >> (DataW - CounterW);

  // shadow copy of the timer registers
  logic [DataW-1:0]    match_q [NumMatch];
  logic [DataW-1:0]    tick_q;
  logic [NumMatch-1:0] status_q;
  logic [NumMatch-1:0] irq_en_q;
  logic                wdog_en_q;

  rsp_t        timer_rsp_q[$];
  rsp_t        want_rsp;
  int unsigned mism;

  // one timer tick: write first, then count, then match compares, then read
  function automatic rsp_t advance_timer(req_t w);
    rsp_t r;
    r = '0;
    if (w.req_type[ReqWriteBit]) begin
      case (w.word_index) inside
        IdxMatch0, IdxMatch1, IdxMatch2, IdxMatch3: match_q[w.word_index[1:0]] = w.write_data;
        IdxStatus: status_q = status_q & ~w.write_data[NumMatch-1:0];
        IdxWdog:   wdog_en_q = w.write_data[0];
        IdxIrqEn:  irq_en_q = w.write_data[NumMatch-1:0];
        default: ;
      endcase
    end
    tick_q = (tick_q + 1'b1) & CntMask;
    for (int k = 0; k < NumMatch; k++) begin
      if (match_q[k] == tick_q && irq_en_q[k]) status_q[k] = 1'b1;
    end
    if (w.req_type[ReqReadBit]) begin
      case (w.word_index) inside
        IdxMatch0, IdxMatch1, IdxMatch2, IdxMatch3: r.read_data = match_q[w.word_index[1:0]];
        IdxCounter: r.read_data = tick_q;
        IdxStatus:  r.read_data = {{(DataW-NumMatch){1'b0}}, status_q};
        IdxWdog:    r.read_data = {{(DataW-1){1'b0}}, wdog_en_q};
        default:    r.read_data = {{(DataW-NumMatch){1'b0}}, irq_en_q};
      endcase
    end
    r.interrupt_lines = status_q & irq_en_q;
    r.watchdog_reset  = (match_q[IdxMatch3[1:0]] == tick_q) && wdog_en_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumMatch; k++) match_q[k] = '0;
      tick_q    = '0;
      status_q  = '0;
      irq_en_q  = '0;
      wdog_en_q = 1'b0;
      timer_rsp_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      mism = 0;
      // retire the older word before queueing the one accepted at this edge
      if (out_valid_i && out_ready_i) begin
        if (timer_rsp_q.size() == 0) begin
          $error("result word with nothing expected: %h", out_data_i);
          mism++;
        end else begin
          want_rsp = timer_rsp_q.pop_front();
          if (out_data_i.read_data !== want_rsp.read_data) begin
            $error("read_data: expected %h, actual %h", want_rsp.read_data,
                   out_data_i.read_data);
            mism++;
          end
          if (out_data_i.interrupt_lines !== want_rsp.interrupt_lines) begin
            $error("interrupt_lines: expected %h, actual %h", want_rsp.interrupt_lines,
                   out_data_i.interrupt_lines);
            mism++;
          end
          if (out_data_i.watchdog_reset !== want_rsp.watchdog_reset) begin
            $error("watchdog_reset: expected %b, actual %b", want_rsp.watchdog_reset,
                   out_data_i.watchdog_reset);
            mism++;
          end
        end
      end
      if (in_valid_i && in_ready_i) timer_rsp_q.push_back(advance_timer(in_data_i));
      fail_cnt_o <= fail_cnt_o + mism;
      pending_o  <= timer_rsp_q.size();
    end
  end

endmodule

// ===== dv/tb_os_timer_match_watchdog.sv =====
// testbench top for the os timer match watchdog: stimulus, stalls and verdict
module tb_os_timer_match_watchdog;
  timeunit 1ns;
  timeprecision 1ps;
  import ostmw_pkg::*;

  localparam int unsigned CntW       = 32;
  localparam int unsigned NumRandom  = 400;
  localparam int unsigned CycleLimit = 100000;

  localparam logic [ReqW-1:0] ReqTick  = 2'd0;
  localparam logic [ReqW-1:0] ReqWr    = 2'd1;
  localparam logic [ReqW-1:0] ReqRd    = 2'd2;
  localparam logic [ReqW-1:0] ReqWrRd  = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt;
  int unsigned burst_left;
  int unsigned gap;
  int unsigned pick;
  int unsigned hold_left;
  int unsigned phase_cnt;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  req_t        rnd_word;

  always #2 clk = ~clk;

  os_timer_match_watchdog #(
    .COUNTER_WIDTH(CntW)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  ostmw_timer_checker #(
    .CounterW(CntW)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("os_timer_match_watchdog regression: fail");
      $finish;
    end
  end

  // offers one tick word and returns at the edge that accepts it
  task automatic send_tick(input logic [ReqW-1:0] req, input logic [IdxW-1:0] idx,
                           input logic [DataW-1:0] data);
    in_valid           <= 1'b1;
    in_data.req_type   <= req;
    in_data.word_index <= idx;
    in_data.write_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly timer traffic that makes matches happen, the rest random noise
  function automatic req_t random_tick();
    req_t w;
    w.req_type   = ReqW'($urandom_range(0, 3));
    w.word_index = IdxW'($urandom_range(0, 7));
    w.write_data = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      w.req_type   = $urandom_range(0, 1) ? ReqWr : ReqWrRd;
      w.word_index = IdxW'($urandom_range(0, NumMatch - 1));
      w.write_data = sent_cnt + $urandom_range(1, 12);
    end else if (pick < 35) begin
      w.req_type[ReqWriteBit] = 1'b1;
      w.word_index            = IdxIrqEn;
    end else if (pick < 43) begin
      w.req_type[ReqWriteBit] = 1'b1;
      w.word_index            = IdxWdog;
    end else if (pick < 53) begin
      w.req_type[ReqWriteBit] = 1'b1;
      w.word_index            = IdxStatus;
    end else if (pick < 58) begin
      w.req_type[ReqWriteBit] = 1'b1;
      w.word_index            = IdxCounter;
    end else if (pick < 93) begin
      w.req_type = $urandom_range(0, 1) ? ReqRd : ReqTick;
    end
    return w;
  endfunction

  // receiver: rotating stall patterns plus one long hold-off on request
  initial begin
    hold_left = 0;
    phase_cnt = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      phase_cnt++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 80;
        out_ready <= 1'b0;
      end else begin
        case ((phase_cnt / 97) % 4)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= phase_cnt[0];
        endcase
      end
    end
  end

  initial begin
    sent_cnt   = 0;
    burst_left = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(ReqTick, IdxMatch0, '0);
    send_tick(ReqRd, IdxCounter, 32'hFFFF_FFFF);
    send_tick(ReqWrRd, IdxIrqEn, 32'hFFFF_FFFF);
    // match written on the very tick it equals the counter
    send_tick(ReqWrRd, IdxMatch0, sent_cnt + 1);
    send_tick(ReqWr, IdxMatch1, 32'hFFFF_FFFF);
    // match 2 with its enable off must not set status
    send_tick(ReqWr, IdxIrqEn, 32'h0000_000B);
    send_tick(ReqWrRd, IdxMatch2, sent_cnt + 1);
    // watchdog fires with irq enable bit 3 off
    send_tick(ReqWr, IdxWdog, 32'hFFFF_FFFF);
    send_tick(ReqWr, IdxIrqEn, 32'h0000_0007);
    send_tick(ReqWr, IdxMatch3, sent_cnt + 2);
    send_tick(ReqRd, IdxWdog, '0);
    send_tick(ReqWrRd, IdxCounter, 32'hFFFF_FFFF);
    // status clear on the same tick as a new match
    send_tick(ReqWr, IdxMatch0, sent_cnt + 2);
    send_tick(ReqWrRd, IdxStatus, 32'h0000_0001);
    send_tick(ReqWrRd, IdxStatus, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) send_tick(ReqRd, IdxW'(i), $urandom());
    send_tick(ReqWr, IdxWdog, 32'hFFFF_FFFE);
    drain_results();

    for (int i = 0; i < NumRandom; i++) begin
      if (i == 100) hold_req = 1'b1;
      if (i == 200 || i == 300) drain_results();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      rnd_word = random_tick();
      send_tick(rnd_word.req_type, rnd_word.word_index, rnd_word.write_data);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("os_timer_match_watchdog regression: pass");
    end else begin
      $display("os_timer_match_watchdog regression: fail");
    end
    $finish;
  end

endmodule
